// ===== rtl/core/cga_interlaced_pixel_fill_engine_macros.svh =====
// Assertion shorthands for the checker file of the fill engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CGA_INTERLACED_PIXEL_FILL_ENGINE_MACROS_SVH
`define CGA_INTERLACED_PIXEL_FILL_ENGINE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CGAIPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CGAIPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cgaipf_pkg.sv =====
`default_nettype none

package cgaipf_pkg;

    // Screen geometry and store layout.
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int ODD_ROW_BASE  = 8192;
    localparam int STORE_DEPTH   = 16384;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // Item field widths.
    localparam int OP_W     = 2;
    localparam int XIN_W    = 9;
    localparam int YIN_W    = 8;
    localparam int COLOR_W  = 2;
    localparam int DATA_W   = 8;

    // Walk coordinate widths: wide enough for the start edge plus the extent.
    localparam int CUR_X_W     = 10;
    localparam int CUR_XE_W    = CUR_X_W + 1;
    localparam int CUR_Y_W     = 9;
    localparam int LIN_W       = 17;
    localparam int ADDR_CALC_W = 17;

    localparam logic [CUR_X_W-1:0] SCREEN_W_X = CUR_X_W'(SCREEN_WIDTH);
    localparam logic [CUR_Y_W-1:0] SCREEN_H_Y = CUR_Y_W'(SCREEN_HEIGHT);

    localparam logic [DATA_W-1:0] PIXEL_MASK   = 8'h03;
    localparam logic [DATA_W-1:0] PACK_PATTERN = 8'h55;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_PLOT = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_READ_PIX,
        CMD_WRITE_PIX,
        CMD_WRITE_BYTE,
        CMD_SKIP_PIX,
        CMD_NEXT_ROW,
        CMD_READ_BYTE,
        CMD_LOAD_OUT
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic rect_done;
        logic row_done;
        logic addr_ok;
        logic byte_ok;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cgaipf_item_if.sv =====
`default_nettype none

interface cgaipf_item_if
    import cgaipf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [XIN_W-1:0]    x;
    logic [YIN_W-1:0]    y;
    logic [XIN_W-1:0]    width;
    logic [YIN_W-1:0]    height;
    logic [COLOR_W-1:0]  color;
    logic [ADDR_W-1:0]   read_address;

    modport source (
        output valid, operation, x, y, width, height, color, read_address,
        input  ready
    );

    modport sink (
        input  valid, operation, x, y, width, height, color, read_address,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/cgaipf_result_if.sv =====
`default_nettype none

interface cgaipf_result_if
    import cgaipf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic               was_read;

    modport source (
        output valid, read_data, was_read,
        input  ready
    );

    modport sink (
        input  valid, read_data, was_read,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/cgaipf_dp.sv =====
`default_nettype none

module cgaipf_dp
    import cgaipf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output dp_status_t          status,
    input  logic [OP_W-1:0]     operation,
    input  logic [XIN_W-1:0]    x,
    input  logic [YIN_W-1:0]    y,
    input  logic [XIN_W-1:0]    width,
    input  logic [YIN_W-1:0]    height,
    input  logic [COLOR_W-1:0]  color,
    input  logic [ADDR_W-1:0]   read_address,
    output logic [DATA_W-1:0]   read_data,
    output logic                was_read
);

    logic [DATA_W-1:0]      frame_store [STORE_DEPTH];

    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CUR_X_W-1:0]     cur_x_reg, cur_x_next;
    logic [CUR_Y_W-1:0]     cur_y_reg, cur_y_next;
    logic [CUR_X_W-1:0]     start_x_reg, start_x_next;
    logic [CUR_X_W-1:0]     end_x_reg, end_x_next;
    logic [CUR_Y_W-1:0]     end_y_reg, end_y_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ADDR_W-1:0]      raddr_reg, raddr_next;
    logic [DATA_W-1:0]      read_data_reg, read_data_next;
    logic                   was_read_reg, was_read_next;
    logic [DATA_W-1:0]      mem_rdata_reg;

    logic [XIN_W-1:0]       w_eff;
    logic [YIN_W-1:0]       h_eff;
    logic [CUR_X_W-1:0]     x_sum;
    logic [CUR_Y_W-1:0]     y_sum;
    logic [LIN_W-1:0]       lin;
    logic [ADDR_CALC_W-1:0] addr_calc;
    logic [ADDR_W-1:0]      pix_addr;
    logic [2:0]             shift;
    logic [DATA_W-1:0]      pix_mask;
    logic [DATA_W-1:0]      color_bits;
    logic [DATA_W-1:0]      merged;
    logic [DATA_W-1:0]      packed_byte;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    // A plot is walked as a one-by-one rectangle.
    always_comb
    begin
        w_eff = (operation == OP_PLOT) ? XIN_W'(1) : width;
        h_eff = (operation == OP_PLOT) ? YIN_W'(1) : height;
        x_sum = CUR_X_W'(x) + CUR_X_W'(w_eff);
        y_sum = CUR_Y_W'(y) + CUR_Y_W'(h_eff);
    end

    // Byte address and bit position of the current pixel.
    always_comb
    begin
        lin = LIN_W'(cur_y_reg[CUR_Y_W-1:1]) * LIN_W'(SCREEN_WIDTH) + LIN_W'(cur_x_reg);
        addr_calc = ADDR_CALC_W'(lin[LIN_W-1:2])
                  + (cur_y_reg[0] ? ADDR_CALC_W'(ODD_ROW_BASE) : '0);
        pix_addr = addr_calc[ADDR_W-1:0];
        // Pixel k of a byte sits at bit 6-2k, which is twice the inverted index.
        shift = {~lin[1:0], 1'b0};
        pix_mask = PIXEL_MASK << shift;
        color_bits = DATA_W'(color_reg) << shift;
        merged = (mem_rdata_reg & ~pix_mask) | color_bits;
        packed_byte = DATA_W'(PACK_PATTERN * DATA_W'(color_reg));
    end

    always_comb
    begin
        status.clear_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
        status.rect_done  = (cur_y_reg >= end_y_reg);
        status.row_done   = (cur_x_reg >= end_x_reg);
        status.addr_ok    = (addr_calc < ADDR_CALC_W'(STORE_DEPTH));
        status.byte_ok    = (lin[1:0] == 2'b00)
                          && ((CUR_XE_W'(cur_x_reg) + CUR_XE_W'(4)) <= CUR_XE_W'(end_x_reg));
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        start_x_next   = start_x_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        color_next     = color_reg;
        op_next        = op_reg;
        raddr_next     = raddr_reg;
        read_data_next = read_data_reg;
        was_read_next  = was_read_reg;
        mem_we         = 1'b0;
        mem_waddr      = pix_addr;
        mem_wdata      = merged;
        mem_re         = 1'b0;
        mem_raddr      = pix_addr;
        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            CMD_LOAD:
            begin
                cur_x_next   = CUR_X_W'(x);
                cur_y_next   = CUR_Y_W'(y);
                start_x_next = CUR_X_W'(x);
                end_x_next   = (x_sum > SCREEN_W_X) ? SCREEN_W_X : x_sum;
                end_y_next   = (y_sum > SCREEN_H_Y) ? SCREEN_H_Y : y_sum;
                color_next   = color;
                op_next      = operation;
                raddr_next   = read_address;
            end
            CMD_READ_PIX:
            begin
                mem_re = 1'b1;
            end
            CMD_WRITE_PIX:
            begin
                mem_we     = 1'b1;
                cur_x_next = cur_x_reg + CUR_X_W'(1);
            end
            CMD_WRITE_BYTE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = packed_byte;
                cur_x_next = cur_x_reg + CUR_X_W'(4);
            end
            CMD_SKIP_PIX:
            begin
                cur_x_next = cur_x_reg + CUR_X_W'(1);
            end
            CMD_NEXT_ROW:
            begin
                cur_x_next = start_x_reg;
                cur_y_next = cur_y_reg + CUR_Y_W'(1);
            end
            CMD_READ_BYTE:
            begin
                mem_re    = 1'b1;
                mem_raddr = raddr_reg;
            end
            CMD_LOAD_OUT:
            begin
                was_read_next  = (op_reg == OP_READ);
                read_data_next = (op_reg == OP_READ) ? mem_rdata_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        start_x_reg   <= start_x_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        color_reg     <= color_next;
        op_reg        <= op_next;
        raddr_reg     <= raddr_next;
        read_data_reg <= read_data_next;
        was_read_reg  <= was_read_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= frame_store[mem_raddr];
        end
    end

    assign read_data = read_data_reg;
    assign was_read  = was_read_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cgaipf_ctrl.sv =====
`default_nettype none

module cgaipf_ctrl
    import cgaipf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [OP_W-1:0]  in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dp_status_t       status,
    output cmd_t             cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MERGE,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_NONE;
        in_ready_next  = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (status.clear_last)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready_next = 1'b1;
                if (in_valid && in_ready_reg)
                begin
                    cmd           = CMD_LOAD;
                    in_ready_next = 1'b0;
                    unique case (in_op) inside
                        OP_PLOT, OP_FILL: state_next = ST_WALK;
                        OP_READ:          state_next = ST_READ;
                        default:          state_next = ST_RESULT;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (status.rect_done)
                begin
                    state_next = ST_RESULT;
                end
                else if (status.row_done)
                begin
                    cmd = CMD_NEXT_ROW;
                end
                else if (!status.addr_ok)
                begin
                    cmd = CMD_SKIP_PIX;
                end
                else if (status.byte_ok)
                begin
                    cmd = CMD_WRITE_BYTE;
                end
                else
                begin
                    cmd        = CMD_READ_PIX;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                cmd        = CMD_WRITE_PIX;
                state_next = ST_WALK;
            end
            ST_READ:
            begin
                cmd        = CMD_READ_BYTE;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_LOAD_OUT;
                    out_valid_next = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cga_interlaced_pixel_fill_engine.sv =====
// Channel   Modport  Handshake     Payload
// request   sink     valid/ready   operation, x, y, width, height, color, read_address
// response  source   valid/ready   read_data, was_read
//
// After reset the block zeroes all 16384 framebuffer bytes, one per cycle, and
// request.ready rises only once the clear is done. One item is worked at a time.
// A read fetches its byte through the registered read port of the framebuffer. A
// fill writes each whole inner byte at once and each other pixel by read-modify-write,
// and ends every row with a row step.
// A stalled response holds its item; the next request waits for the output register.
`default_nettype none

module cga_interlaced_pixel_fill_engine
    import cgaipf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    cgaipf_item_if.sink     request,
    cgaipf_result_if.source response
);

    // The controller sequences the clearing pass, the rectangle walk and the
    // read; the datapath owns the framebuffer, the walk coordinates and the
    // output register.
    cmd_t       cmd;
    dp_status_t status;

    cgaipf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_op     (request.operation),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // A plot is handled as a rectangle one pixel wide and one row high, so both
    // operations share the clipping and the read-modify-write path. Pixels off
    // the screen are removed by clipping the rectangle edges when the item is
    // loaded.
    cgaipf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (request.operation),
        .x            (request.x),
        .y            (request.y),
        .width        (request.width),
        .height       (request.height),
        .color        (request.color),
        .read_address (request.read_address),
        .read_data    (response.read_data),
        .was_read     (response.was_read)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cgaipf_checker.sv =====
`default_nettype none

`include "cga_interlaced_pixel_fill_engine_macros.svh"

module cgaipf_checker
    import cgaipf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic [DATA_W-1:0]  rsp_read_data,
    input  logic               rsp_was_read
);

    // Only one item is worked at a time, so acceptance closes the request side.
    `CGAIPF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request ready after accept")

    // Plot, fill and unused operations always answer with a zero byte.
    `CGAIPF_ASSERT_IMPL(a_zero_unless_read, rsp_valid && !rsp_was_read, rsp_read_data == '0, "nonzero data on non-read response")

    // A stalled response keeps its item.
    `CGAIPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_was_read), "stalled response changed")

endmodule

bind cga_interlaced_pixel_fill_engine cgaipf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .rsp_valid     (response.valid),
    .rsp_ready     (response.ready),
    .rsp_read_data (response.read_data),
    .rsp_was_read  (response.was_read)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cgaipf_pkg::*;

    // Operation code that the block ignores. It still answers with an empty result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Number of random items after the directed part.
    localparam int RANDOM_ITEMS = 1850;

    // Cycles allowed after the last awaited result, so that a stray extra
    // response still has time to show up.
    localparam int DRAIN_CYCLES = 40;

    // Hard stop for a hung run. The slowest correct run adds the clear of the
    // whole store after reset, at most a read and a write for every visited pixel
    // of every fill, the worst sender gap and receiver stall on every item, and the
    // handful of full-screen fills. This limit is set several times above that sum.
    localparam int CYCLE_LIMIT = 8_000_000;

    // One input item as the testbench sees it.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [XIN_W-1:0]   x;
        logic [YIN_W-1:0]   y;
        logic [XIN_W-1:0]   width;
        logic [YIN_W-1:0]   height;
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  read_address;
    } pixel_request_t;

    // One result item.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              was_read;
    } pixel_reply_t;

    // Shadow copy of the framebuffer. Every accepted item is applied here in
    // order, and the reply that it must produce is queued. Responses from the
    // block are matched against the oldest queued reply.
    class cga_frame_shadow;
        logic [DATA_W-1:0] frame_bytes [STORE_DEPTH];
        logic [XIN_W-1:0]  last_fill_column;
        logic [YIN_W-1:0]  last_fill_row;
        pixel_reply_t      awaited_replies [$];
        int mismatches;
        int responses_checked;
        int plots;
        int fills;
        int reads;
        int unused_items;
        int pixels_painted;

        function new();
            foreach (frame_bytes[i])
            begin
                frame_bytes[i] = '0;
            end
            last_fill_column  = '0;
            last_fill_row     = '0;
            mismatches        = 0;
            responses_checked = 0;
            plots             = 0;
            fills             = 0;
            reads             = 0;
            unused_items      = 0;
            pixels_painted    = 0;
        endfunction

        // Read-modify-write of one pixel. Off-screen pixels and addresses past
        // the end of the store are dropped.
        function void paint_pixel(int px, int py, logic [COLOR_W-1:0] color);
            int lin;
            int addr;
            int shift;
            if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            begin
                return;
            end
            lin  = (py / 2) * SCREEN_WIDTH + px;
            addr = lin / 4;
            if (py % 2 == 1)
            begin
                addr += ODD_ROW_BASE;
            end
            if (addr >= STORE_DEPTH)
            begin
                return;
            end
            shift = 6 - 2 * (lin % 4);
            frame_bytes[addr] = (frame_bytes[addr] & ~(PIXEL_MASK << shift))
                                | (DATA_W'(color) << shift);
            pixels_painted++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // Applies one accepted request and queues the reply it must cause.
        function void take_item(pixel_request_t it);
            int col_end;
            int row_end;
            pixel_reply_t reply;
            reply = '0;
            case (it.operation)
                OP_PLOT:
                begin
                    plots++;
                    paint_pixel(int'(it.x), int'(it.y), it.color);
                end
                OP_FILL:
                begin
                    fills++;
                    // An empty rectangle leaves the walk position untouched.
                    if (it.width != 0 && it.height != 0)
                    begin
                        col_end = int'(it.x) + int'(it.width);
                        row_end = int'(it.y) + int'(it.height);
                        if (col_end > SCREEN_WIDTH)
                        begin
                            col_end = SCREEN_WIDTH;
                        end
                        if (row_end > SCREEN_HEIGHT)
                        begin
                            row_end = SCREEN_HEIGHT;
                        end
                        for (int row = int'(it.y); row < row_end; row++)
                        begin
                            for (int col = int'(it.x); col < col_end; col++)
                            begin
                                paint_pixel(col, row, it.color);
                            end
                        end
                        last_fill_column = XIN_W'(int'(it.x) + int'(it.width) - 1);
                        last_fill_row    = YIN_W'(int'(it.y) + int'(it.height) - 1);
                    end
                end
                OP_READ:
                begin
                    reads++;
                    reply.read_data = frame_bytes[it.read_address];
                    reply.was_read  = 1'b1;
                end
                OP_UNUSED:
                begin
                    unused_items++;
                end
            endcase
            awaited_replies.push_back(reply);
        endfunction

        // Compares one accepted response with the oldest awaited reply.
        task match_response(logic [DATA_W-1:0] data, logic was_read);
            pixel_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                report_mismatch($sformatf("stray response: read_data=%02h was_read=%0b",
                                          data, was_read));
                return;
            end
            want = awaited_replies.pop_front();
            responses_checked++;
            if (data !== want.read_data)
            begin
                report_mismatch($sformatf("read_data %02h, expected %02h (response %0d)",
                                          data, want.read_data, responses_checked));
            end
            if (was_read !== want.was_read)
            begin
                report_mismatch($sformatf("was_read %0b, expected %0b (response %0d)",
                                          was_read, want.was_read, responses_checked));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;

    // When a quiet flag is set, that side runs back to back without idling.
    logic send_quiet;
    logic take_quiet;

    cga_frame_shadow frame_shadow;

    cgaipf_item_if   request_ch ();
    cgaipf_result_if response_ch ();

    cga_interlaced_pixel_fill_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic pixel_request_t make_request(logic [OP_W-1:0] op, int x, int y,
                                                    int width, int height, int color,
                                                    int read_address);
        pixel_request_t it;
        it.operation    = op;
        it.x            = XIN_W'(x);
        it.y            = YIN_W'(y);
        it.width        = XIN_W'(width);
        it.height       = YIN_W'(height);
        it.color        = COLOR_W'(color);
        it.read_address = ADDR_W'(read_address);
        return it;
    endfunction

    // Random item. Fields that the operation ignores still carry random bits,
    // so every bit of every field toggles. Most coordinates stay on screen so
    // that plots and fills land where reads can see them; reads mostly aim at
    // bytes that hold visible pixels.
    function automatic pixel_request_t draw_request();
        pixel_request_t it;
        int pick;
        int px;
        int py;
        int lin;
        it.x            = XIN_W'($urandom);
        it.y            = YIN_W'($urandom);
        it.width        = XIN_W'($urandom);
        it.height       = YIN_W'($urandom);
        it.color        = COLOR_W'($urandom);
        it.read_address = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            it.operation = OP_PLOT;
            // A tenth of the plots keep full-range coordinates and often fall off screen.
            if ($urandom_range(9) != 0)
            begin
                it.x = XIN_W'($urandom_range(SCREEN_WIDTH - 1));
                it.y = YIN_W'($urandom_range(SCREEN_HEIGHT - 1));
            end
        end
        else if (pick < 65)
        begin
            it.operation = OP_READ;
            if ($urandom_range(4) < 3)
            begin
                px  = $urandom_range(SCREEN_WIDTH - 1);
                py  = $urandom_range(SCREEN_HEIGHT - 1);
                lin = (py / 2) * SCREEN_WIDTH + px;
                it.read_address = ADDR_W'(lin / 4 + (py % 2) * ODD_ROW_BASE);
            end
        end
        else if (pick < 95)
        begin
            it.operation = OP_FILL;
            pick = $urandom_range(99);
            if (pick < 2)
            begin
                // Nearly the whole screen; these are the slow ones, so they stay rare.
                it.x      = XIN_W'($urandom_range(15));
                it.y      = YIN_W'($urandom_range(7));
                it.width  = XIN_W'($urandom_range(SCREEN_WIDTH, SCREEN_WIDTH - 20));
                it.height = YIN_W'($urandom_range(SCREEN_HEIGHT, SCREEN_HEIGHT - 10));
            end
            else if (pick < 8)
            begin
                // Full-range position and width, only a few rows.
                it.height = YIN_W'($urandom_range(3));
            end
            else if (pick < 14)
            begin
                // Full-range position and height, only a few columns.
                it.width = XIN_W'($urandom_range(4));
            end
            else
            begin
                it.x      = XIN_W'($urandom_range(SCREEN_WIDTH - 1));
                it.y      = YIN_W'($urandom_range(SCREEN_HEIGHT - 1));
                it.width  = XIN_W'($urandom_range(40));
                it.height = YIN_W'($urandom_range(16));
            end
        end
        else
        begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    // Presents one item after a random gap and returns at the edge where it is
    // accepted. With no gap, valid simply stays high into the next item.
    task automatic send_request(input pixel_request_t it);
        int gap;
        if ($urandom_range(39) == 0)
        begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(9);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid        <= 1'b1;
        request_ch.operation    <= it.operation;
        request_ch.x            <= it.x;
        request_ch.y            <= it.y;
        request_ch.width        <= it.width;
        request_ch.height       <= it.height;
        request_ch.color        <= it.color;
        request_ch.read_address <= it.read_address;
        @(posedge clk);
        while (!request_ch.ready)
        begin
            @(posedge clk);
        end
        frame_shadow.take_item(it);
    endtask

    // Response side: before each result the receiver stalls for a random number
    // of cycles, then holds ready high until a result is taken. Signals are
    // sampled right after the edge, so they hold the values the block saw.
    initial
    begin : response_taker
        int stall;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if ($urandom_range(39) == 0)
            begin
                take_quiet = !take_quiet;
            end
            stall = take_quiet ? 0 : $urandom_range(9);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            @(posedge clk);
            while (!response_ch.valid)
            begin
                @(posedge clk);
            end
            frame_shadow.match_response(response_ch.read_data, response_ch.was_read);
        end
    end

    initial
    begin : stimulus
        frame_shadow = new();
        send_quiet   = 1'b0;
        take_quiet   = 1'b0;

        rst_n                   = 1'b0;
        request_ch.valid        = 1'b0;
        request_ch.operation    = OP_PLOT;
        request_ch.x            = '0;
        request_ch.y            = '0;
        request_ch.width        = '0;
        request_ch.height       = '0;
        request_ch.color        = '0;
        request_ch.read_address = '0;
        response_ch.ready       = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The store must read back as zero after the clear, at both ends.
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_READ, 511, 255, 511, 255, 3, STORE_DEPTH - 1));

        // Plots in the corners and a shared byte, then read them back.
        send_request(make_request(OP_PLOT, 0, 0, 0, 0, 3, 0));
        send_request(make_request(OP_PLOT, 1, 0, 0, 0, 1, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_PLOT, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 2, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 16191));
        send_request(make_request(OP_PLOT, 0, SCREEN_HEIGHT - 1, 0, 0, 1, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, ODD_ROW_BASE + 7920));

        // Off-screen plots must be dropped: column past the edge, row past the
        // bottom, and both fields at their maximum.
        send_request(make_request(OP_PLOT, SCREEN_WIDTH, 0, 0, 0, 3, 0));
        send_request(make_request(OP_PLOT, 0, SCREEN_HEIGHT, 0, 0, 3, 0));
        send_request(make_request(OP_PLOT, 511, 255, 0, 0, 3, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 80));

        // A full-screen fill packs every byte; then empty rectangles change nothing.
        send_request(make_request(OP_FILL, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_FILL, 0, 0, 0, 10, 2, 0));
        send_request(make_request(OP_FILL, 0, 0, 10, 0, 2, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 16191));

        // A rectangle clipped at the bottom right, and a ragged one whose edges
        // share bytes with pixels outside it.
        send_request(make_request(OP_FILL, SCREEN_WIDTH - 2, SCREEN_HEIGHT - 2, 511, 255, 2, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 16191));
        send_request(make_request(OP_FILL, 5, 3, 7, 2, 3, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, ODD_ROW_BASE + 81));

        // The unused operation code answers with an empty result.
        send_request(make_request(OP_UNUSED, 511, 255, 511, 255, 3, STORE_DEPTH - 1));

        // Largest field values for a fill, then clear the screen for the random part.
        send_request(make_request(OP_FILL, 0, 0, 511, 255, 2, 0));
        send_request(make_request(OP_FILL, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 0, 0));

        repeat (RANDOM_ITEMS)
        begin
            send_request(draw_request());
        end
        request_ch.valid <= 1'b0;

        while (frame_shadow.awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d plots, %0d fills (%0d pixels), %0d reads, %0d unused codes.",
                 frame_shadow.plots, frame_shadow.fills, frame_shadow.pixels_painted,
                 frame_shadow.reads, frame_shadow.unused_items);
        $display("Responses compared: %0d, mismatches: %0d.",
                 frame_shadow.responses_checked, frame_shadow.mismatches);
        if (frame_shadow.mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cgaipf_pkg.sv
rtl/core/cgaipf_item_if.sv
rtl/core/cgaipf_result_if.sv
rtl/core/cgaipf_dp.sv
rtl/core/cgaipf_ctrl.sv
rtl/core/cga_interlaced_pixel_fill_engine.sv
rtl/core/cgaipf_checker.sv
tb/sv/tb_top.sv
